// ----- rtl/port_gap_cluster_ranges_macros.svh -----
// assertion helpers for the port gap clusterer
`ifndef PORT_GAP_CLUSTER_RANGES_MACROS_SVH
`define PORT_GAP_CLUSTER_RANGES_MACROS_SVH
`ifndef SYNTHESIS
`define PGCR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgcr assertion failed");
`define PGCR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgcr assertion failed");
`else
`define PGCR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PGCR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/pgcr_pkg.sv -----
package pgcr_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [1:0] REG_GAP    = 2'd0;
  localparam logic [1:0] REG_MARGIN = 2'd1;
  localparam logic [1:0] REG_TILE   = 2'd2;

  localparam logic [15:0] PORT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] gap_limit;
    logic [15:0] margin_width;
    logic [16:0] tile_limit;
  } cfg_t;

endpackage

// ----- rtl/pgcr_in_if.sv -----
interface pgcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] port_first;
  logic [15:0] port_end;

  modport source (output valid, operation, port_first, port_end, input ready);
  modport sink (input valid, operation, port_first, port_end, output ready);
endinterface

// ----- rtl/pgcr_out_if.sv -----
interface pgcr_out_if;
  logic        valid;
  logic        ready;
  logic        range_found;
  logic [15:0] range_first;
  logic [15:0] range_last;
  logic [16:0] tile_count;
  logic [15:0] hidden_count;
  logic [16:0] used_count;

  modport source (output valid, range_found, range_first, range_last, tile_count,
                  hidden_count, used_count, input ready);
  modport sink (input valid, range_found, range_first, range_last, tile_count,
                hidden_count, used_count, output ready);
endinterface

// ----- rtl/pgcr_ram.sv -----
module pgcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/pgcr_cfg.sv -----
module pgcr_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output pgcr_pkg::cfg_t cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_limit    <= 16'd0;
      cfg.margin_width <= 16'd0;
      cfg.tile_limit   <= 17'd1;
    end else if (wr) begin
      case (paddr[3:2])
        pgcr_pkg::REG_GAP:    cfg.gap_limit    <= pwdata[15:0];
        pgcr_pkg::REG_MARGIN: cfg.margin_width <= pwdata[15:0];
        pgcr_pkg::REG_TILE:   cfg.tile_limit   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pgcr_pkg::REG_GAP:    prdata = {16'd0, cfg.gap_limit};
      pgcr_pkg::REG_MARGIN: prdata = {16'd0, cfg.margin_width};
      pgcr_pkg::REG_TILE:   prdata = {15'd0, cfg.tile_limit};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/port_gap_cluster_ranges.sv -----
// Port gap clusterer. Ranges of used ports are marked in a word-wide bitmap held in a
// single-port RAM (PORT_SPACE/MAP_WORD_BITS words, MAP_WORD_BITS a power of two); one
// request returns the next cluster above the cursor, widened by the margin. After reset
// and after every clear, a clearing pass writes each map word once and no item is taken
// meanwhile. An add reads and then writes back each map word that the range touches. A
// request is served by one bit-step unit walking the map in the scan, the join and the
// used count: it steps port by port up to the last used port of a word, skips the rest of
// a word in a single step, fetches each map word it needs through the fetch and load
// states, ends each walk with a step of its own, then sets up the window and loads the
// result, so its length depends on the data. The block takes one item at a time; a result
// waits in its output register while the next item is accepted, and a request that finds
// that register still full waits until it drains.
`include "port_gap_cluster_ranges_macros.svh"

module port_gap_cluster_ranges #(
  parameter int PORT_SPACE    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  pgcr_in_if.sink     request,
  pgcr_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WORDS = (PORT_SPACE + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW    = $clog2(WORDS);
  localparam int OFFW  = $clog2(MAP_WORD_BITS);
  localparam logic [16:0] PS      = 17'(PORT_SPACE);
  localparam logic [16:0] PS_LAST = 17'(PORT_SPACE - 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [OFFW-1:0] TOP_BIT = OFFW'(MAP_WORD_BITS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_ADD_RD = 4'd2;
  localparam logic [3:0] S_ADD_WR = 4'd3;
  localparam logic [3:0] S_FETCH  = 4'd4;
  localparam logic [3:0] S_LOAD   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_JOIN   = 4'd7;
  localparam logic [3:0] S_WIN    = 4'd8;
  localparam logic [3:0] S_COUNT  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  pgcr_pkg::cfg_t cfg;

  logic [3:0]  state, ret;
  logic [AW-1:0] clr_idx;
  logic [16:0] p, lo, hi, cursor, cnt;
  logic [MAP_WORD_BITS-1:0] wd;
  logic [15:0] first, last, wfirst, wlast;
  logic        found;

  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata, mask, ones;

  logic [OFFW-1:0] offp;
  logic        bitv, rest_zero, last_bit, step_fetch;
  logic [16:0] p_inc, p_skip, step_p;
  logic        same_word;
  logic [16:0] lo_skip;
  logic [15:0] end_port;
  logic [16:0] end_c;
  logic        add_ok, accept;
  logic [16:0] span, gap_dist;
  logic [17:0] first_m;
  logic [16:0] last_p;
  logic [15:0] wf_c, wl_c;
  logic [16:0] total, tiles, tile_c;
  logic [15:0] hidden_c;

  pgcr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  pgcr_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(WORDS)) u_map (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // bit-step unit shared by scan, join and count
  assign offp       = p[OFFW-1:0];
  assign bitv       = wd[offp];
  assign rest_zero  = (wd >> offp) == '0;
  assign last_bit   = offp == TOP_BIT;
  assign p_inc      = p + 17'd1;
  assign p_skip     = 17'(((p >> OFFW) + 17'd1) << OFFW);
  assign step_p     = rest_zero ? p_skip : p_inc;
  assign step_fetch = rest_zero || last_bit;

  // add: mask for the part of the range that falls in the current word
  assign ones      = '1;
  assign same_word = (lo >> OFFW) == (hi >> OFFW);
  assign mask      = (ones << lo[OFFW-1:0]) &
                     (same_word ? (ones >> (TOP_BIT - hi[OFFW-1:0])) : ones);
  assign lo_skip   = 17'(((lo >> OFFW) + 17'd1) << OFFW);

  assign end_port = (request.port_end != 16'd0) ? request.port_end : request.port_first;
  assign end_c    = ({1'b0, end_port} > PS_LAST) ? PS_LAST : {1'b0, end_port};
  assign add_ok   = !(request.port_end != 16'd0 && request.port_end < request.port_first) &&
                    ({1'b0, request.port_first} < PS);

  assign span     = {1'b0, cfg.gap_limit} + 17'd1;
  assign gap_dist = p - {1'b0, last};

  // window, clamped to 1..65535
  assign first_m = {2'b00, first} - {2'b00, cfg.margin_width};
  assign wf_c    = (first_m[17] || first_m == 18'd0) ? 16'd1 : first_m[15:0];
  assign last_p  = {1'b0, last} + {1'b0, cfg.margin_width};
  assign wl_c    = last_p[16] ? pgcr_pkg::PORT_MAX : last_p[15:0];

  assign total    = (wlast >= wfirst) ? ({1'b0, wlast} - {1'b0, wfirst} + 17'd1) : 17'd0;
  assign tiles    = (cfg.tile_limit == 17'd0) ? 17'd1 : cfg.tile_limit;
  assign tile_c   = (total < tiles) ? total : tiles;
  assign hidden_c = (total > tiles) ? 16'(total - tiles) : 16'd0;

  assign request.ready = state == S_IDLE;
  assign accept        = request.valid && request.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_idx;
      end
      S_ADD_RD: ram_addr = AW'(lo >> OFFW);
      S_ADD_WR: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(lo >> OFFW);
        ram_wdata = ram_rdata | mask;
      end
      S_FETCH: ram_addr = AW'(p >> OFFW);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      cursor       <= 17'd0;
      result.valid <= 1'b0;
    end else begin
      // the result load in S_OUT sets valid itself
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (request.operation)
              pgcr_pkg::OP_CLEAR: begin
                clr_idx <= '0;
                cursor  <= 17'd0;
                state   <= S_CLEAR;
              end
              pgcr_pkg::OP_ADD: begin
                if (add_ok) begin
                  lo    <= {1'b0, request.port_first};
                  hi    <= end_c;
                  state <= S_ADD_RD;
                end
              end
              pgcr_pkg::OP_NEXT: begin
                p     <= cursor;
                ret   <= S_SCAN;
                state <= S_FETCH;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_idx == LAST_WORD) begin
            state <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          if (same_word) begin
            state <= S_IDLE;
          end else begin
            lo    <= lo_skip;
            state <= S_ADD_RD;
          end
        end
        S_FETCH: state <= (p >= PS) ? ret : S_LOAD;
        S_LOAD: begin
          wd    <= ram_rdata;
          state <= ret;
        end
        S_SCAN: begin
          if (p >= PS) begin
            found  <= 1'b0;
            cursor <= PS;
            state  <= S_OUT;
          end else if (bitv) begin
            found <= 1'b1;
            first <= p[15:0];
            last  <= p[15:0];
            p     <= p_inc;
            ret   <= S_JOIN;
            state <= last_bit ? S_FETCH : S_JOIN;
          end else begin
            p <= step_p;
            if (step_fetch) begin
              state <= S_FETCH;
            end
          end
        end
        S_JOIN: begin
          if (p >= PS || gap_dist > span) begin
            cursor <= {1'b0, last} + 17'd1;
            state  <= S_WIN;
          end else if (bitv) begin
            last <= p[15:0];
            p    <= p_inc;
            if (last_bit) begin
              state <= S_FETCH;
            end
          end else begin
            p <= step_p;
            if (step_fetch) begin
              state <= S_FETCH;
            end
          end
        end
        S_WIN: begin
          wfirst <= wf_c;
          wlast  <= wl_c;
          p      <= {1'b0, wf_c};
          cnt    <= 17'd0;
          ret    <= S_COUNT;
          state  <= S_FETCH;
        end
        S_COUNT: begin
          if (p >= PS || p > {1'b0, wlast}) begin
            state <= S_OUT;
          end else if (bitv) begin
            cnt <= cnt + 17'd1;
            p   <= p_inc;
            if (last_bit) begin
              state <= S_FETCH;
            end
          end else begin
            p <= step_p;
            if (step_fetch) begin
              state <= S_FETCH;
            end
          end
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.range_found  <= found;
            result.range_first  <= found ? wfirst : 16'd0;
            result.range_last   <= found ? wlast : 16'd0;
            result.tile_count   <= found ? tile_c : 17'd0;
            result.hidden_count <= found ? hidden_c : 16'd0;
            result.used_count   <= found ? cnt : 17'd0;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PGCR_ASSERT_IMP(a_none_is_zero, clk, rst, result.valid && !result.range_found, result.range_first == 16'd0 && result.range_last == 16'd0 && result.used_count == 17'd0)
  `PGCR_ASSERT_IMP(a_cursor_range, clk, rst, 1'b1, cursor <= PS)
  `PGCR_ASSERT_NXT(a_clear_busy, clk, rst, accept && request.operation == pgcr_pkg::OP_CLEAR, !request.ready)
  `PGCR_ASSERT_IMP(a_tiles_nonzero, clk, rst, result.valid && result.range_found && result.range_first <= result.range_last, result.tile_count != 17'd0)

endmodule
